// ----- design/ordered_list_insert_remove_core_macros.svh -----
// Assertion macros for the ordered list insert/remove core.
// No dependencies; included by the top level.
`ifndef ORDERED_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define ORDERED_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define OLIR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define OLIR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/olir_pkg.sv -----
// Shared types for the ordered list insert/remove core.
// No dependencies; used by olir_cell and the top level.
`timescale 1ns / 1ps

package olir_pkg;

    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_e;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic              fire;
        kind_e             kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- design/olir_cell.sv -----
// One slot of the list row: holds, loads, or takes a neighbor's entry.
// Depends on olir_pkg.
`timescale 1ns / 1ps

module olir_cell #(
    parameter int INDEX = 0
) (
    input  logic                              clk,
    input  olir_pkg::cell_ctrl_t              ctrl,
    input  logic [olir_pkg::DATA_W-1:0]       left_data,
    input  logic [olir_pkg::DATA_W-1:0]       right_data,
    output logic [olir_pkg::DATA_W-1:0]       data,
    output logic [olir_pkg::DATA_W-1:0]       tap
);
    import olir_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_pos;
    logic              past_pos;

    assign at_pos   = (INDEX == int'(ctrl.pos));
    assign past_pos = (INDEX > int'(ctrl.pos));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.fire)
        begin
            unique case (ctrl.kind)
                KIND_INSERT:
                begin
                    if (at_pos)
                        data_next = ctrl.value;
                    else if (past_pos)
                        data_next = left_data;
                end
                KIND_REMOVE:
                begin
                    // entries at and after the hole move forward
                    if (at_pos || past_pos)
                        data_next = right_data;
                end
                default: data_next = data_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign tap  = at_pos ? data_reg : '0;

endmodule

// ----- design/ordered_list_insert_remove_core.sv -----
// Ordered positional list of up to DEPTH signed 32-bit entries, kept in a row
// of cells. One item (insert or remove at a position) is accepted per cycle; its
// result beat appears in the output register the cycle after acceptance. The
// rate is one item per cycle, set by the cell update and the one
// output register; input ready drops only while a result waits unaccepted.
// Slots hold no reset value: only entries below the current length are read.
// Depends on olir_pkg, olir_cell and the assertion macro header.
`timescale 1ns / 1ps

`include "ordered_list_insert_remove_core_macros.svh"

module ordered_list_insert_remove_core #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  logic [olir_pkg::POS_W-1:0]        position,
    input  logic signed [olir_pkg::DATA_W-1:0] value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic signed [olir_pkg::DATA_W-1:0] removed_value,
    output logic [olir_pkg::LEN_W-1:0]        length
);
    import olir_pkg::*;

    // Count must hold DEPTH itself; comparisons run at the wider of the
    // count and position widths.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Control state
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Result payload
    logic              ok_reg;
    logic [DATA_W-1:0] removed_reg;
    logic [LEN_W-1:0]  length_reg;

    logic             in_fire;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cnt_next_ext;
    logic             ins_ok;
    logic             rem_ok;
    logic             op_ok;
    kind_e            op_kind;
    cell_ctrl_t       ctrl;
    logic [DATA_W-1:0] sel_data;

    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_tap  [DEPTH];

    // Handshake: the output register parts the two sides
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Legality checks against the current count
    assign op_kind = kind_e'(kind);
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign ins_ok  = (count_reg < CNT_W'(DEPTH)) && (pos_ext <= cnt_ext);
    assign rem_ok  = (count_reg != '0) && (pos_ext < cnt_ext);

    always_comb
    begin
        unique case (op_kind)
            KIND_INSERT: op_ok = ins_ok;
            KIND_REMOVE: op_ok = rem_ok;
            default:     op_ok = 1'b0;
        endcase
    end

    // Broadcast to the row; cells only move on a legal operation
    assign ctrl.fire  = in_fire && op_ok;
    assign ctrl.kind  = op_kind;
    assign ctrl.pos   = position;
    assign ctrl.value = value;

    // Row of cells: each takes its left neighbor on insert, its right on remove
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_left
            assign left_in = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = '0;
        end
        else
        begin : g_right
            assign right_in = cell_data[i+1];
        end

        olir_cell #(
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[i]),
            .tap        (cell_tap[i])
        );
    end

    // Only the cell at the position drives its tap
    always_comb
    begin
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++)
            sel_data = sel_data | cell_tap[i];
    end

    // Entry count
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.fire)
        begin
            unique case (op_kind)
                KIND_INSERT: count_next = count_reg + CNT_W'(1);
                KIND_REMOVE: count_next = count_reg - CNT_W'(1);
                default:     count_next = count_reg;
            endcase
        end
    end

    assign cnt_next_ext = CMP_W'(count_next);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ok_reg      <= op_ok;
            removed_reg <= (op_ok && (op_kind == KIND_REMOVE)) ? sel_data : '0;
            length_reg  <= cnt_next_ext[LEN_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign removed_value = removed_reg;
    assign length        = length_reg;

    // Checks
    `OLIR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH),
        "entry count exceeds depth")
    `OLIR_ASSERT_NEXT(a_reject_holds, clk, rst_n, in_fire && !op_ok,
        count_reg == $past(count_reg), "rejected operation changed the count")
    `OLIR_ASSERT_NEXT(a_insert_grows, clk, rst_n, in_fire && ins_ok && (op_kind == KIND_INSERT),
        count_reg == $past(count_reg) + CNT_W'(1), "accepted insert did not grow the list")
    `OLIR_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid_reg && !ok_reg, removed_reg == '0,
        "failed operation returned a nonzero value")

endmodule
